### hdl/gwko_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the gray-with-keyed-logo-overlay block
// no dependencies

package gwko_pkg;

  // default sizing, handed to the top level parameters
  localparam int LOGO_PIXELS_DEF = 4096;
  localparam int COORD_BITS_DEF  = 12;

  // field and register widths
  localparam int PIX_W      = 8;
  localparam int IMG_DIM_W  = 13;
  localparam int LOGO_DIM_W = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int MODE_W     = 2;

  // logo offsets and addresses inside a window
  localparam int LOGO_ADDR_W = 2 * LOGO_DIM_W;

  // register reset values
  localparam logic [IMG_DIM_W-1:0]  IMAGE_WIDTH_RST  = IMG_DIM_W'(640);
  localparam logic [IMG_DIM_W-1:0]  IMAGE_HEIGHT_RST = IMG_DIM_W'(480);
  localparam logic [LOGO_DIM_W-1:0] LOGO_DIM_RST     = LOGO_DIM_W'(64);

  // q0.16 bt.709 luma weights, they sum to 65536
  localparam int LUMA_W = 16;
  localparam logic [LUMA_W-1:0] LUMA_COEF_R = LUMA_W'(13933);
  localparam logic [LUMA_W-1:0] LUMA_COEF_G = LUMA_W'(46871);
  localparam logic [LUMA_W-1:0] LUMA_COEF_B = LUMA_W'(4732);
  localparam int LUMA_SUM_W = PIX_W + LUMA_W;

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  // item kinds on the input channel
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_CENTER = 2'd0,
    MODE_LOAD_CORNER = 2'd1,
    MODE_PHOTO       = 2'd2
  } mode_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH        = 3'd0,
    CFG_IMAGE_HEIGHT       = 3'd1,
    CFG_CENTER_LOGO_WIDTH  = 3'd2,
    CFG_CENTER_LOGO_HEIGHT = 3'd3,
    CFG_CORNER_LOGO_WIDTH  = 3'd4,
    CFG_CORNER_LOGO_HEIGHT = 3'd5
  } cfg_reg_e;

endpackage

### hdl/gray_with_keyed_logo_overlay.sv
`timescale 1ns / 1ps
// top level: bt.709 gray conversion with a color-keyed centered logo and a
// copied bottom-right logo; depends on gwko_pkg
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------------
//   in      | in_valid_i / in_stall_o  | mode_i first_i red_in_i green_in_i blue_in_i
//   out     | out_valid_o / out_stall_i| red_out_o green_out_o blue_out_o frame_last_o
//   cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i cfg_data_i
//
// one item per clock unless a full output register is stalled; a photo pixel passes
// window math, address multiply, logo store read and output register, in that order
// the pipeline moves as one: it holds whenever the output register is full
// and stalled, so in_stall_o follows out_stall_i in that case only
// loads write the logo stores in the same stage where photo pixels read
// them, so the store access order equals the input order
// reset clears counters and valid bits and restores the config defaults; data
// registers and the logo stores are not cleared, the stores read as garbage until loaded

module gray_with_keyed_logo_overlay #(
  parameter int LOGO_PIXELS = gwko_pkg::LOGO_PIXELS_DEF,
  parameter int COORD_BITS  = gwko_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel requests
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gwko_pkg::MODE_W-1:0]     mode_i,
  input  logic                            first_i,
  input  logic [gwko_pkg::PIX_W-1:0]      red_in_i,
  input  logic [gwko_pkg::PIX_W-1:0]      green_in_i,
  input  logic [gwko_pkg::PIX_W-1:0]      blue_in_i,
  // result requests
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gwko_pkg::PIX_W-1:0]      red_out_o,
  output logic [gwko_pkg::PIX_W-1:0]      green_out_o,
  output logic [gwko_pkg::PIX_W-1:0]      blue_out_o,
  output logic                            frame_last_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gwko_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gwko_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PW   = gwko_pkg::PIX_W;
  localparam int IW   = gwko_pkg::IMG_DIM_W;
  localparam int LW   = gwko_pkg::LOGO_DIM_W;
  localparam int PAW  = gwko_pkg::LOGO_ADDR_W;
  localparam int CW   = COORD_BITS;
  // store index and load address (the latter can hold the store depth)
  localparam int AW   = (LOGO_PIXELS > 1) ? $clog2(LOGO_PIXELS) : 1;
  localparam int LAW  = $clog2(LOGO_PIXELS + 1);
  // compare width for end of row / frame
  localparam int CMPW = (CW + 1 > IW) ? CW + 1 : IW;
  // signed width for window origins and offsets
  localparam int SW   = ((CW > IW) ? CW : IW) + 2;
  // width for the logo address range check
  localparam int XW   = ((AW > PAW) ? AW : PAW) + 1;
  localparam int RGBW = 3 * PW;
  localparam int LSW  = gwko_pkg::LUMA_SUM_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [IW-1:0] img_w_q, img_h_q;
  logic [LW-1:0] cen_w_q, cen_h_q, cor_w_q, cor_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= gwko_pkg::IMAGE_WIDTH_RST;
      img_h_q <= gwko_pkg::IMAGE_HEIGHT_RST;
      cen_w_q <= gwko_pkg::LOGO_DIM_RST;
      cen_h_q <= gwko_pkg::LOGO_DIM_RST;
      cor_w_q <= gwko_pkg::LOGO_DIM_RST;
      cor_h_q <= gwko_pkg::LOGO_DIM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gwko_pkg::CFG_IMAGE_WIDTH:        img_w_q <= cfg_data_i[IW-1:0];
        gwko_pkg::CFG_IMAGE_HEIGHT:       img_h_q <= cfg_data_i[IW-1:0];
        gwko_pkg::CFG_CENTER_LOGO_WIDTH:  cen_w_q <= cfg_data_i[LW-1:0];
        gwko_pkg::CFG_CENTER_LOGO_HEIGHT: cen_h_q <= cfg_data_i[LW-1:0];
        gwko_pkg::CFG_CORNER_LOGO_WIDTH:  cor_w_q <= cfg_data_i[LW-1:0];
        gwko_pkg::CFG_CORNER_LOGO_HEIGHT: cor_h_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;
  logic in_acc;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;

  logic is_photo, is_ld_cen, is_ld_cor;
  assign is_photo  = (mode_i == gwko_pkg::MODE_PHOTO);
  assign is_ld_cen = (mode_i == gwko_pkg::MODE_LOAD_CENTER);
  assign is_ld_cor = (mode_i == gwko_pkg::MODE_LOAD_CORNER);

  // ---------------------------------------------------------------------------
  // raster and load counters, updated at accept
  // ---------------------------------------------------------------------------
  logic [CW-1:0]  col_q, row_q, col_d, row_d, col_use, row_use;
  logic [LAW-1:0] ld_addr_q, ld_addr_d, ld_use;
  logic           last_col, last_frame, ld_ok;

  assign col_use = first_i ? '0 : col_q;
  assign row_use = first_i ? '0 : row_q;
  assign ld_use  = first_i ? '0 : ld_addr_q;
  assign ld_ok   = (ld_use < LAW'(LOGO_PIXELS));

  assign last_col   = (CMPW'(col_use) + CMPW'(1)) >= CMPW'(img_w_q);
  assign last_frame = last_col && ((CMPW'(row_use) + CMPW'(1)) >= CMPW'(img_h_q));

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    ld_addr_d = ld_addr_q;
    if (in_acc && is_photo) begin
      if (last_frame) begin
        col_d = '0;
        row_d = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = row_use + CW'(1);
      end else begin
        col_d = col_use + CW'(1);
        row_d = row_use;
      end
    end else if (in_acc && (is_ld_cen || is_ld_cor)) begin
      // address sticks at the store depth, later writes are dropped
      ld_addr_d = ld_ok ? (ld_use + LAW'(1)) : ld_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      ld_addr_q <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      ld_addr_q <= ld_addr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // window tests on the incoming coordinate
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] img_w_s, img_h_s, x_s, y_s;
  logic signed [SW-1:0] cen_dx, cen_dy, cen_dx_adj, cen_dy_adj, cen_ox, cen_oy;
  logic signed [SW-1:0] cor_ox, cor_oy;
  logic signed [SW-1:0] cen_j, cen_i, cor_j, cor_i;
  logic                 cen_in, cor_in;

  assign img_w_s = $signed(SW'(img_w_q));
  assign img_h_s = $signed(SW'(img_h_q));
  assign x_s     = $signed(SW'(col_use));
  assign y_s     = $signed(SW'(row_use));

  // centered origin: half the difference, rounded toward zero
  assign cen_dx     = img_w_s - $signed(SW'(cen_w_q));
  assign cen_dy     = img_h_s - $signed(SW'(cen_h_q));
  assign cen_dx_adj = cen_dx + $signed(SW'(cen_dx[SW-1]));
  assign cen_dy_adj = cen_dy + $signed(SW'(cen_dy[SW-1]));
  assign cen_ox     = cen_dx_adj >>> 1;
  assign cen_oy     = cen_dy_adj >>> 1;

  assign cor_ox = img_w_s - $signed(SW'(cor_w_q));
  assign cor_oy = img_h_s - $signed(SW'(cor_h_q));

  assign cen_j = x_s - cen_ox;
  assign cen_i = y_s - cen_oy;
  assign cor_j = x_s - cor_ox;
  assign cor_i = y_s - cor_oy;

  assign cen_in = !cen_j[SW-1] && !cen_i[SW-1]
               && ($unsigned(cen_j) < SW'(cen_w_q))
               && ($unsigned(cen_i) < SW'(cen_h_q));
  assign cor_in = !cor_j[SW-1] && !cor_i[SW-1]
               && ($unsigned(cor_j) < SW'(cor_w_q))
               && ($unsigned(cor_i) < SW'(cor_h_q));

  // ---------------------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------------------
  logic           s1_photo_q, s1_ld_cen_q, s1_ld_cor_q;
  logic [PW-1:0]  s1_red_q, s1_green_q, s1_blue_q;
  logic           s1_last_q;
  logic           s1_cen_in_q, s1_cor_in_q;
  logic [LW-1:0]  s1_cen_i_q, s1_cen_j_q, s1_cor_i_q, s1_cor_j_q;
  logic [AW-1:0]  s1_ld_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_photo_q  <= 1'b0;
      s1_ld_cen_q <= 1'b0;
      s1_ld_cor_q <= 1'b0;
    end else if (adv) begin
      s1_photo_q  <= in_acc && is_photo;
      s1_ld_cen_q <= in_acc && is_ld_cen && ld_ok;
      s1_ld_cor_q <= in_acc && is_ld_cor && ld_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_red_q    <= red_in_i;
      s1_green_q  <= green_in_i;
      s1_blue_q   <= blue_in_i;
      s1_last_q   <= last_frame;
      s1_cen_in_q <= cen_in;
      s1_cor_in_q <= cor_in;
      s1_cen_i_q  <= cen_i[LW-1:0];
      s1_cen_j_q  <= cen_j[LW-1:0];
      s1_cor_i_q  <= cor_i[LW-1:0];
      s1_cor_j_q  <= cor_j[LW-1:0];
      s1_ld_idx_q <= ld_use[AW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: logo address (row * width + column), luma products
  // ---------------------------------------------------------------------------
  logic [PAW-1:0] cen_addr, cor_addr;
  logic [XW-1:0]  cen_addr_x, cor_addr_x;
  logic           cen_rng, cor_rng;

  assign cen_addr   = PAW'(s1_cen_i_q) * PAW'(cen_w_q) + PAW'(s1_cen_j_q);
  assign cor_addr   = PAW'(s1_cor_i_q) * PAW'(cor_w_q) + PAW'(s1_cor_j_q);
  assign cen_addr_x = XW'(cen_addr);
  assign cor_addr_x = XW'(cor_addr);
  assign cen_rng    = cen_addr_x < XW'(LOGO_PIXELS);
  assign cor_rng    = cor_addr_x < XW'(LOGO_PIXELS);

  logic            s2_photo_q, s2_ld_cen_q, s2_ld_cor_q;
  logic            s2_cen_hit_q, s2_cor_hit_q, s2_last_q;
  logic [AW-1:0]   s2_cen_idx_q, s2_cor_idx_q;
  logic [RGBW-1:0] s2_rgb_q;
  logic            s2_key_q;
  logic [LSW-1:0]  s2_pr_q, s2_pg_q, s2_pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_photo_q  <= 1'b0;
      s2_ld_cen_q <= 1'b0;
      s2_ld_cor_q <= 1'b0;
    end else if (adv) begin
      s2_photo_q  <= s1_photo_q;
      s2_ld_cen_q <= s1_ld_cen_q;
      s2_ld_cor_q <= s1_ld_cor_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_cen_hit_q <= s1_cen_in_q && cen_rng;
      s2_cor_hit_q <= s1_cor_in_q && cor_rng;
      s2_last_q    <= s1_last_q;
      // loads and photo reads share the store address
      s2_cen_idx_q <= s1_ld_cen_q ? s1_ld_idx_q : cen_addr_x[AW-1:0];
      s2_cor_idx_q <= s1_ld_cor_q ? s1_ld_idx_q : cor_addr_x[AW-1:0];
      s2_rgb_q     <= {s1_red_q, s1_green_q, s1_blue_q};
      s2_key_q     <= (s1_red_q != gwko_pkg::PIX_MAX);
      s2_pr_q      <= LSW'(s1_red_q)   * LSW'(gwko_pkg::LUMA_COEF_R);
      s2_pg_q      <= LSW'(s1_green_q) * LSW'(gwko_pkg::LUMA_COEF_G);
      s2_pb_q      <= LSW'(s1_blue_q)  * LSW'(gwko_pkg::LUMA_COEF_B);
    end
  end

  // ---------------------------------------------------------------------------
  // logo stores: one access per cycle while the pipeline advances, registered read
  // ---------------------------------------------------------------------------
  logic            key_mem [LOGO_PIXELS];
  logic [RGBW-1:0] cor_mem [LOGO_PIXELS];
  logic            key_rd_q;
  logic [RGBW-1:0] cor_rd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s2_ld_cen_q) begin
        key_mem[s2_cen_idx_q] <= s2_key_q;
      end
      key_rd_q <= key_mem[s2_cen_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s2_ld_cor_q) begin
        cor_mem[s2_cor_idx_q] <= s2_rgb_q;
      end
      cor_rd_q <= cor_mem[s2_cor_idx_q];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: luma sum alongside the store read
  // ---------------------------------------------------------------------------
  logic          s3_photo_q, s3_cen_hit_q, s3_cor_hit_q, s3_last_q;
  logic [PW-1:0] s3_gray_q;
  logic [LSW-1:0] luma_sum;

  // weights sum to 1.0 in q0.16, so the sum never overflows
  assign luma_sum = s2_pr_q + s2_pg_q + s2_pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_photo_q <= 1'b0;
    end else if (adv) begin
      s3_photo_q <= s2_photo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_cen_hit_q <= s2_cen_hit_q;
      s3_cor_hit_q <= s2_cor_hit_q;
      s3_last_q    <= s2_last_q;
      s3_gray_q    <= luma_sum[LSW-1 -: PW];
    end
  end

  // ---------------------------------------------------------------------------
  // overlay and output register
  // ---------------------------------------------------------------------------
  logic [PW-1:0] red_d, green_d, blue_d;
  logic [PW-1:0] cor_red;

  assign cor_red = cor_rd_q[RGBW-1 -: PW];

  always_comb begin
    red_d   = s3_gray_q;
    green_d = s3_gray_q;
    blue_d  = s3_gray_q;
    // center logo marks red and blue, green stays gray
    if (s3_cen_hit_q && key_rd_q) begin
      red_d  = gwko_pkg::PIX_MAX;
      blue_d = gwko_pkg::PIX_MAX;
    end
    // corner logo wins over everything where its red is not full
    if (s3_cor_hit_q && (cor_red != gwko_pkg::PIX_MAX)) begin
      red_d   = cor_red;
      green_d = cor_rd_q[PW +: PW];
      blue_d  = cor_rd_q[PW-1:0];
    end
  end

  logic [PW-1:0] red_q, green_q, blue_q;
  logic          last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_photo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      last_q  <= s3_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign frame_last_o = last_q;

endmodule
